[src/cdte_pkg.sv]
package cdte_pkg;

    // Field widths of the date and epoch transactions.
    localparam int YEAR_W  = 11;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int EPOCH_W = 36;
    localparam int DOY_W   = 9;
    localparam int WDAY_W  = 3;

    // Internal widths.
    localparam int FULL_W  = 12;  // full calendar year, 1900 to 3947
    localparam int DAYS_W  = 20;  // days since 1970-01-01
    localparam int TOD_W   = 17;  // seconds within the day
    localparam int ZSUM_W  = 9;   // Zeller sum before the mod 7

    // Calendar constants.
    localparam logic [FULL_W-1:0] FULL_YEAR_BASE = 12'd1900;
    localparam logic [YEAR_W-1:0] FIRST_YEAR     = 11'd70;
    localparam logic [YEAR_W-1:0] LEAP_BASE      = 11'd69;
    localparam logic [FULL_W-1:0] GREG_OFFSET    = 12'd299;
    localparam int                GREG_CYCLE     = 400;
    localparam int                GREG_COUNT_MAX = 5;
    localparam logic [12:0]       RECIP_100      = 13'd5243;  // 2^19 / 100, rounded up
    localparam logic [FULL_W-1:0] CENTURY        = 12'd100;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR  = 20'd365;
    localparam logic [TOD_W-1:0]  SECS_PER_HOUR  = 17'd3600;
    localparam logic [TOD_W-1:0]  SECS_PER_MIN   = 17'd60;
    localparam logic [TOD_W-1:0]  SECS_PER_DAY   = 17'd86400;
    localparam logic [HOUR_W-1:0] HOUR_MAX       = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX        = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_MAX        = 6'd59;
    localparam logic [DOY_W-1:0]  DOY_MAX        = 9'd365;
    localparam logic [WDAY_W-1:0] WDAY_MAX       = 3'd6;

    // Month numbers.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // First pipeline stage: raw fields and the products of the reciprocal multiplies.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   mday;
        logic [FULL_W-1:0]  full;
        logic [5:0]         q_full;
        logic [4:0]         q_ym1;
        logic [FULL_W-1:0]  zy;
        logic [5:0]         q_zy;
        logic [DAYS_W-1:0]  days365;
        logic [TOD_W-1:0]   tod;
        logic               range_ok;
    } t_cal_s1;

    // Calendar result handed to the seconds stages.
    typedef struct packed {
        logic               ok;
        logic [DAYS_W-1:0]  days;
        logic [TOD_W-1:0]   tod;
        logic [DOY_W-1:0]   doy;
        logic               leap;
        logic [ZSUM_W-1:0]  zsum;
    } t_cal_res;

    // Stage after the day-to-second multiply.
    typedef struct packed {
        logic               ok;
        logic [EPOCH_W-1:0] prod;
        logic [TOD_W-1:0]   tod;
        logic [DOY_W-1:0]   doy;
        logic               leap;
        logic [WDAY_W-1:0]  wday;
    } t_sec_s3;

    // Days in the year before the first of the month.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] mon);
        logic [DOY_W-1:0] d;
        case (mon)
            MONTH_JAN: d = 9'd0;
            MONTH_FEB: d = 9'd31;
            MONTH_MAR: d = 9'd59;
            MONTH_APR: d = 9'd90;
            MONTH_MAY: d = 9'd120;
            MONTH_JUN: d = 9'd151;
            MONTH_JUL: d = 9'd181;
            MONTH_AUG: d = 9'd212;
            MONTH_SEP: d = 9'd243;
            MONTH_OCT: d = 9'd273;
            MONTH_NOV: d = 9'd304;
            MONTH_DEC: d = 9'd334;
            default:   d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of the month, February taking the leap flag.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (mon)
            MONTH_FEB: d = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // Zeller month term floor(13 * (m + 1) / 5), January and February as months 13 and 14.
    function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] mon);
        logic [5:0] t;
        case (mon)
            MONTH_JAN: t = 6'd36;
            MONTH_FEB: t = 6'd39;
            MONTH_MAR: t = 6'd10;
            MONTH_APR: t = 6'd13;
            MONTH_MAY: t = 6'd15;
            MONTH_JUN: t = 6'd18;
            MONTH_JUL: t = 6'd20;
            MONTH_AUG: t = 6'd23;
            MONTH_SEP: t = 6'd26;
            MONTH_OCT: t = 6'd28;
            MONTH_NOV: t = 6'd31;
            MONTH_DEC: t = 6'd33;
            default:   t = 6'd0;
        endcase
        return t;
    endfunction

    // Remainder by 7: octal digits are summed, since 8 is 1 modulo 7.
    function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] a);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [WDAY_W-1:0] r;
        s1 = 5'(a[8:6]) + 5'(a[5:3]) + 5'(a[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7) begin
            r = 3'(s2 - 4'd7);
        end else begin
            r = s2[2:0];
        end
        return r;
    endfunction

endpackage

[src/cdte_date_if.sv]
interface cdte_date_if;
    import cdte_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_since_1900;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;

    modport source (
        output valid, year_since_1900, month, day, hour, minute, second,
        input  ready
    );

    modport sink (
        input  valid, year_since_1900, month, day, hour, minute, second,
        output ready
    );
endinterface

[src/cdte_epoch_if.sv]
interface cdte_epoch_if;
    import cdte_pkg::*;

    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [EPOCH_W-1:0] epoch_seconds;
    logic [DOY_W-1:0]   day_of_year;
    logic               leap_year;
    logic [WDAY_W-1:0]  weekday;

    modport source (
        output valid, valid_res, epoch_seconds, day_of_year, leap_year, weekday,
        input  ready
    );

    modport sink (
        input  valid, valid_res, epoch_seconds, day_of_year, leap_year, weekday,
        output ready
    );
endinterface

[src/cdte_calendar.sv]
module cdte_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cdte_date_if.sink          i_date,
    output logic               o_valid,
    input  logic               i_ready,
    output cdte_pkg::t_cal_res o_cal
);
    import cdte_pkg::*;

    logic     r1_valid;
    logic     r2_valid;
    t_cal_s1  r1;
    t_cal_s1  n1;
    t_cal_res r2;
    t_cal_res n2;
    logic     w_s1_rdy;
    logic     w_s2_rdy;

    logic [FULL_W-1:0] w_full;
    logic [YEAR_W-1:0] w_ym1;
    logic [FULL_W-1:0] w_zy;
    logic [24:0]       w_full_prod;
    logic [23:0]       w_ym1_prod;
    logic [24:0]       w_zy_prod;

    logic [FULL_W-1:0] w_rem_full;
    logic [FULL_W-1:0] w_rem_zy;
    logic              w_leap;
    logic [DAY_W-1:0]  w_mlen;
    logic [DOY_W-1:0]  w_doy;
    logic [FULL_W-1:0] w_y299;
    logic [2:0]        w_q400;
    logic [YEAR_W-1:0] w_y69;
    logic [6:0]        w_k;
    logic [5:0]        w_j;

    // Ready ripples back so that a bubble in either stage is filled.
    assign w_s2_rdy     = !r2_valid || i_ready;
    assign w_s1_rdy     = !r1_valid || w_s2_rdy;
    assign i_date.ready = w_s1_rdy;

    // Stage 1: full year and reciprocal multiplies for the divisions by 100.
    assign w_full      = {1'b0, i_date.year_since_1900} + FULL_YEAR_BASE;
    assign w_ym1       = i_date.year_since_1900 - 11'd1;
    assign w_zy        = (i_date.month < MONTH_MAR) ? (w_full - 12'd1) : w_full;
    assign w_full_prod = {13'b0, w_full} * {12'b0, RECIP_100};
    assign w_ym1_prod  = {13'b0, w_ym1} * {11'b0, RECIP_100};
    assign w_zy_prod   = {13'b0, w_zy} * {12'b0, RECIP_100};

    always_comb begin
        n1.year     = i_date.year_since_1900;
        n1.month    = i_date.month;
        n1.mday     = i_date.day;
        n1.full     = w_full;
        n1.q_full   = w_full_prod[24:19];
        n1.q_ym1    = w_ym1_prod[23:19];
        n1.zy       = w_zy;
        n1.q_zy     = w_zy_prod[24:19];
        n1.days365  = {9'b0, i_date.year_since_1900 - FIRST_YEAR} * DAYS_PER_YEAR;
        n1.tod      = {12'b0, i_date.hour} * SECS_PER_HOUR
                    + {11'b0, i_date.minute} * SECS_PER_MIN
                    + {11'b0, i_date.second};
        n1.range_ok = (i_date.year_since_1900 >= FIRST_YEAR)
                    && (i_date.month != 4'd0) && (i_date.month <= MONTH_DEC)
                    && (i_date.hour <= HOUR_MAX)
                    && (i_date.minute <= MIN_MAX)
                    && (i_date.second <= SEC_MAX);
    end

    // Stage 2: leap rule on the full year, day checks and day of year.
    assign w_rem_full = r1.full - ({6'b0, r1.q_full} * CENTURY);
    assign w_leap     = (r1.full[1:0] == 2'b00)
                      && ((w_rem_full != 12'd0) || (r1.q_full[1:0] == 2'b00));
    assign w_mlen     = month_days(r1.month, w_leap);
    assign w_doy      = days_before_month(r1.month) + {4'b0, r1.mday} - 9'd1
                      + {8'b0, w_leap && (r1.month > MONTH_FEB)};

    // Gregorian correction count: floor((year + 299) / 400) takes at most five steps.
    assign w_y299 = {1'b0, r1.year} + GREG_OFFSET;
    always_comb begin
        w_q400 = 3'd0;
        for (int k = 1; k <= GREG_COUNT_MAX; k++) begin
            if (w_y299 >= 12'(k * GREG_CYCLE)) begin
                w_q400 = w_q400 + 3'd1;
            end
        end
    end

    assign w_y69 = r1.year - LEAP_BASE;

    // Zeller terms: K is the adjusted year mod 100, J the century.
    assign w_rem_zy = r1.zy - ({6'b0, r1.q_zy} * CENTURY);
    assign w_k      = w_rem_zy[6:0];
    assign w_j      = r1.q_zy;

    always_comb begin
        n2.ok   = r1.range_ok && (r1.mday != 5'd0) && (r1.mday <= w_mlen);
        n2.days = r1.days365 + {11'b0, w_y69[10:2]} + {17'b0, w_q400}
                - {15'b0, r1.q_ym1} + {11'b0, w_doy};
        n2.tod  = r1.tod;
        n2.doy  = w_doy;
        n2.leap = w_leap;
        n2.zsum = {4'b0, r1.mday} + {3'b0, zeller_month_term(r1.month)}
                + {2'b0, w_k} + {4'b0, w_k[6:2]} + {5'b0, w_j[5:2]}
                + {1'b0, w_j, 2'b00} + {3'b0, w_j};
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (w_s1_rdy) begin
                r1_valid <= i_date.valid;
            end
            if (w_s2_rdy) begin
                r2_valid <= r1_valid;
            end
        end
    end

    // Payload registers load only when their stage takes a transaction.
    always_ff @(posedge i_clk) begin
        if (w_s1_rdy && i_date.valid) begin
            r1 <= n1;
        end
        if (w_s2_rdy && r1_valid) begin
            r2 <= n2;
        end
    end

    assign o_valid = r2_valid;
    assign o_cal   = r2;

`ifndef ASSERT_OFF
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && !i_ready |=> r2_valid && $stable(r2))
        else $error("stage 2 lost or changed a stalled transaction");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && !w_s2_rdy |=> r1_valid && $stable(r1))
        else $error("stage 1 lost or changed a stalled transaction");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && r2.ok |-> (r2.doy <= DOY_MAX) && (r2.tod < SECS_PER_DAY))
        else $error("valid date with day of year or time of day out of range");
`endif
endmodule

[src/cdte_seconds.sv]
module cdte_seconds (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cdte_pkg::t_cal_res i_cal,
    cdte_epoch_if.source       o_epoch
);
    import cdte_pkg::*;

    logic                r3_valid;
    logic                r4_valid;
    t_sec_s3             r3;
    t_sec_s3             n3;
    logic                w_s3_rdy;
    logic                w_s4_rdy;

    logic                r4_valid_res;
    logic [EPOCH_W-1:0]  r4_epoch;
    logic [DOY_W-1:0]    r4_doy;
    logic                r4_leap;
    logic [WDAY_W-1:0]   r4_wday;
    logic [EPOCH_W-1:0]  n4_epoch;

    // Ready ripples back through the output register and the product stage.
    assign w_s4_rdy = !r4_valid || o_epoch.ready;
    assign w_s3_rdy = !r3_valid || w_s4_rdy;
    assign o_ready  = w_s3_rdy;

    // Stage 3: days to seconds, and the weekday remainder.
    always_comb begin
        n3.ok   = i_cal.ok;
        n3.prod = {16'b0, i_cal.days} * {19'b0, SECS_PER_DAY};
        n3.tod  = i_cal.tod;
        n3.doy  = i_cal.doy;
        n3.leap = i_cal.leap;
        n3.wday = mod7(i_cal.zsum);
    end

    // Stage 4: add the time of day.
    assign n4_epoch = r3.prod + {19'b0, r3.tod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (w_s3_rdy) begin
                r3_valid <= i_valid;
            end
            if (w_s4_rdy) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // Output register: every field but the flag is cleared for an invalid date.
    always_ff @(posedge i_clk) begin
        if (w_s3_rdy && i_valid) begin
            r3 <= n3;
        end
        if (w_s4_rdy && r3_valid) begin
            r4_valid_res <= r3.ok;
            r4_epoch     <= r3.ok ? n4_epoch : '0;
            r4_doy       <= r3.ok ? r3.doy : '0;
            r4_leap      <= r3.ok && r3.leap;
            r4_wday      <= r3.ok ? r3.wday : '0;
        end
    end

    assign o_epoch.valid         = r4_valid;
    assign o_epoch.valid_res     = r4_valid_res;
    assign o_epoch.epoch_seconds = r4_epoch;
    assign o_epoch.day_of_year   = r4_doy;
    assign o_epoch.leap_year     = r4_leap;
    assign o_epoch.weekday       = r4_wday;

`ifndef ASSERT_OFF
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid && !w_s4_rdy |=> r3_valid && $stable(r3))
        else $error("stage 3 lost or changed a stalled transaction");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_epoch.valid && !o_epoch.valid_res |->
            (o_epoch.epoch_seconds == '0) && (o_epoch.day_of_year == '0)
            && !o_epoch.leap_year && (o_epoch.weekday == '0))
        else $error("invalid date with nonzero result fields");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_epoch.valid && o_epoch.valid_res |->
            (o_epoch.weekday <= WDAY_MAX) && (o_epoch.day_of_year <= DOY_MAX))
        else $error("weekday or day of year out of range");
`endif
endmodule

[src/calendar_date_to_epoch.sv]
// Channel   Direction  Transaction
// i_date    in         year_since_1900, month, day, hour, minute, second
// o_epoch   out        valid_res, epoch_seconds, day_of_year, leap_year, weekday
//
// One date is accepted per cycle while i_date.ready is high; its result passes through
// four register stages: the reciprocal multiplies, the calendar checks and
// day count, the 20 by 17 bit days-to-seconds multiply, and the output register.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stall on o_epoch holds each full stage in place; ready ripples back so that
// empty stages keep filling and nothing is lost or repeated.
module calendar_date_to_epoch (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdte_date_if.sink     i_date,
    cdte_epoch_if.source  o_epoch
);
    import cdte_pkg::*;

    logic     w_cal_valid;
    logic     w_cal_ready;
    t_cal_res w_cal;

    // Date checks and day count.
    cdte_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (i_date),
        .o_valid (w_cal_valid),
        .i_ready (w_cal_ready),
        .o_cal   (w_cal)
    );

    // Seconds, weekday and output register.
    cdte_seconds u_seconds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cal_valid),
        .o_ready (w_cal_ready),
        .i_cal   (w_cal),
        .o_epoch (o_epoch)
    );
endmodule

[sim/calendar_date_to_epoch_tb.sv]
`timescale 1ns / 1ps

module calendar_date_to_epoch_tb;
    import cdte_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 8;
    localparam int IDLE_PCT    = 18;
    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;

    localparam longint SECS_YEAR = 31536000;
    localparam longint SECS_DAY  = 86400;
    localparam longint SECS_HOUR = 3600;
    localparam longint SECS_MIN  = 60;

    // One date transaction and one epoch transaction, at the block's widths.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_date;

    typedef struct packed {
        logic               valid_res;
        logic [EPOCH_W-1:0] epoch_seconds;
        logic [DOY_W-1:0]   day_of_year;
        logic               leap_year;
        logic [WDAY_W-1:0]  weekday;
    } t_epoch;

    logic i_clk;
    logic i_rst_n;

    cdte_date_if  date_if ();
    cdte_epoch_if epoch_if ();

    calendar_date_to_epoch dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (date_if),
        .o_epoch (epoch_if)
    );

    t_epoch pending_epochs[$];
    int     fail_count    = 0;
    int     cycle_count   = 0;
    bit     src_idle_on   = 1'b1;
    bit     sink_idle_on  = 1'b1;
    int     sink_hold_req = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Gregorian leap rule on the full calendar year.
    function automatic bit is_leap_year(input int full_year);
        return (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
    endfunction

    // Length of a month; zero for a month number outside 1 to 12.
    function automatic int month_len(input logic [MONTH_W-1:0] mon, input bit leap);
        case (mon)
            MONTH_FEB: return leap ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: return 31;
            default: return 0;
        endcase
    endfunction

    // Expected epoch transaction for one date; all zero when any field is out of range.
    function automatic t_epoch date_to_epoch(input t_date d);
        t_epoch r;
        int     y;
        int     full;
        bit     leap;
        int     doy;
        longint secs;
        int     zm;
        int     zy;
        int     k;
        int     j;
        r    = '0;
        y    = int'(d.year);
        full = y + 1900;
        leap = is_leap_year(full);
        if (d.year < FIRST_YEAR || d.month < MONTH_JAN || d.month > MONTH_DEC) begin
            return r;
        end
        if (d.day == 0 || int'(d.day) > month_len(d.month, leap) || d.hour > HOUR_MAX ||
            d.minute > MIN_MAX || d.second > SEC_MAX) begin
            return r;
        end

        // Day of the year: whole months before this one, then the day itself.
        doy = int'(d.day) - 1;
        for (int m = 1; m < int'(d.month); m++) begin
            doy += month_len(MONTH_W'(m), 1'b0);
        end
        if (leap && d.month > MONTH_FEB) begin
            doy += 1;
        end

        // Whole years at 365 days, then the leap days of the Gregorian rule.
        secs = longint'(d.second) + longint'(d.minute) * SECS_MIN +
               longint'(d.hour) * SECS_HOUR + longint'(doy) * SECS_DAY +
               longint'(y - 70) * SECS_YEAR +
               longint'((y - 69) / 4) * SECS_DAY +
               longint'((y + 299) / 400) * SECS_DAY -
               longint'((y - 1) / 100) * SECS_DAY;

        // Zeller's congruence, January and February belonging to the year before.
        if (d.month < MONTH_MAR) begin
            zm = int'(d.month) + 12;
            zy = full - 1;
        end else begin
            zm = int'(d.month);
            zy = full;
        end
        k = zy % 100;
        j = zy / 100;

        r.valid_res     = 1'b1;
        r.epoch_seconds = EPOCH_W'(secs);
        r.day_of_year   = DOY_W'(doy);
        r.leap_year     = leap;
        r.weekday       = WDAY_W'((int'(d.day) + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j)
                                  % 7);
        return r;
    endfunction

    function automatic t_date mk_date(input int y, input int mo, input int dd,
                                      input int h, input int mi, input int s);
        t_date d;
        d.year   = YEAR_W'(y);
        d.month  = MONTH_W'(mo);
        d.day    = DAY_W'(dd);
        d.hour   = HOUR_W'(h);
        d.minute = MIN_W'(mi);
        d.second = SEC_W'(s);
        return d;
    endfunction

    // Mostly well-formed dates, some with one field broken, the rest raw noise.
    function automatic t_date random_date();
        t_date d;
        int    sel;
        int    len;
        sel = $urandom_range(99);
        if ($urandom_range(9) < 9) begin
            d.year = YEAR_W'($urandom_range(200, 70));
        end else begin
            d.year = YEAR_W'($urandom_range(2047, 70));
        end
        d.month = MONTH_W'($urandom_range(12, 1));
        len     = month_len(d.month, is_leap_year(int'(d.year) + 1900));
        if ($urandom_range(4) == 0) begin
            d.day = DAY_W'(len);
        end else begin
            d.day = DAY_W'($urandom_range(len, 1));
        end
        d.hour   = HOUR_W'($urandom_range(23));
        d.minute = MIN_W'($urandom_range(59));
        d.second = SEC_W'($urandom_range(59));
        if (sel >= 75 && sel < 90) begin
            case ($urandom_range(5))
                0: d.year   = YEAR_W'($urandom_range(69));
                1: d.month  = ($urandom_range(1) == 0) ? '0 : MONTH_W'($urandom_range(15, 13));
                2: d.day    = ($urandom_range(1) == 0) ? '0 : DAY_W'($urandom_range(31, len + 1));
                3: d.hour   = HOUR_W'($urandom_range(31, 24));
                4: d.minute = MIN_W'($urandom_range(63, 60));
                default: d.second = SEC_W'($urandom_range(63, 60));
            endcase
        end else if (sel >= 90) begin
            d = t_date'({$urandom, $urandom});
        end
        return d;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    // Predict on every accepted date; check every accepted epoch transaction.
    always @(posedge i_clk) begin
        t_epoch got;
        t_epoch want;
        if (i_rst_n && date_if.valid && date_if.ready) begin
            pending_epochs.push_back(date_to_epoch({date_if.year_since_1900, date_if.month,
                                                    date_if.day, date_if.hour,
                                                    date_if.minute, date_if.second}));
        end
        if (i_rst_n && epoch_if.valid && epoch_if.ready) begin
            got = {epoch_if.valid_res, epoch_if.epoch_seconds, epoch_if.day_of_year,
                   epoch_if.leap_year, epoch_if.weekday};
            if (pending_epochs.size() == 0) begin
                note_failure("epoch transaction with none expected");
            end else begin
                want = pending_epochs.pop_front();
                if (got.valid_res !== want.valid_res ||
                    got.epoch_seconds !== want.epoch_seconds ||
                    got.day_of_year !== want.day_of_year ||
                    got.leap_year !== want.leap_year ||
                    got.weekday !== want.weekday) begin
                    note_failure($sformatf(
                        "mismatch exp v=%0d s=%0d doy=%0d leap=%0d wd=%0d got v=%0d s=%0d doy=%0d leap=%0d wd=%0d",
                        want.valid_res, want.epoch_seconds, want.day_of_year,
                        want.leap_year, want.weekday, got.valid_res, got.epoch_seconds,
                        got.day_of_year, got.leap_year, got.weekday));
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[calendar_date_to_epoch] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, a requested long hold, or always ready.
    initial begin
        int hold_left;
        hold_left = 0;
        epoch_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (!i_rst_n) begin
                epoch_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                epoch_if.ready <= 1'b0;
                hold_left--;
            end else if (sink_idle_on) begin
                epoch_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                epoch_if.ready <= 1'b1;
            end
        end
    end

    // Offer one date and return at the edge where it is accepted.
    task automatic send_date(input t_date d);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            date_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        date_if.valid           <= 1'b1;
        date_if.year_since_1900 <= d.year;
        date_if.month           <= d.month;
        date_if.day             <= d.day;
        date_if.hour            <= d.hour;
        date_if.minute          <= d.minute;
        date_if.second          <= d.second;
        @(posedge i_clk);
        while (!(date_if.valid && date_if.ready)) begin
            @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected transaction has come back.
    task automatic wait_drain();
        date_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_epochs.size() != 0);
    endtask

    task automatic test_directed();
        send_date(mk_date(70, 1, 1, 0, 0, 0));          // the epoch itself
        send_date(mk_date(2047, 12, 31, 23, 59, 59));   // last valid instant
        send_date(mk_date(69, 1, 1, 0, 0, 0));          // year just too early
        send_date(mk_date(0, 0, 0, 0, 0, 0));
        send_date(mk_date(100, 2, 29, 12, 0, 0));       // 2000 is a leap year
        send_date(mk_date(200, 2, 29, 0, 0, 0));        // 2100 is not
        send_date(mk_date(200, 2, 28, 1, 2, 3));
        send_date(mk_date(124, 2, 29, 6, 30, 0));
        send_date(mk_date(123, 2, 29, 6, 30, 0));
        send_date(mk_date(124, 2, 30, 6, 30, 0));
        send_date(mk_date(124, 0, 10, 0, 0, 0));
        send_date(mk_date(124, 13, 10, 0, 0, 0));
        send_date(mk_date(124, 15, 31, 31, 63, 63));
        send_date(mk_date(124, 4, 31, 0, 0, 0));
        send_date(mk_date(124, 4, 30, 0, 0, 0));
        send_date(mk_date(124, 6, 15, 24, 0, 0));
        send_date(mk_date(124, 6, 15, 23, 60, 0));
        send_date(mk_date(124, 6, 15, 23, 0, 60));
        send_date(mk_date(124, 6, 15, 23, 63, 63));
        send_date(mk_date(100, 1, 1, 0, 0, 0));         // weekday from the previous year
        send_date(mk_date(100, 3, 1, 0, 0, 0));
        send_date(mk_date(138, 1, 19, 3, 14, 7));
        send_date(mk_date(124, 12, 31, 23, 59, 59));    // last day of a leap year
        send_date(mk_date(124, 7, 0, 0, 0, 0));
        send_date(mk_date(2047, 15, 31, 31, 63, 63));
        wait_drain();
    endtask

    task automatic test_random_traffic();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (500) begin
            send_date(random_date());
        end
        wait_drain();
    endtask

    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (300) begin
            send_date(random_date());
        end
        wait_drain();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Long receiver hold while dates keep coming, so the pipeline fills and stalls.
    task automatic test_output_hold();
        src_idle_on   = 1'b0;
        sink_hold_req = 80;
        repeat (80) begin
            send_date(random_date());
        end
        wait_drain();
        src_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        date_if.valid           <= 1'b0;
        date_if.year_since_1900 <= '0;
        date_if.month           <= '0;
        date_if.day             <= '0;
        date_if.hour            <= '0;
        date_if.minute          <= '0;
        date_if.second          <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic();
        test_back_to_back();
        test_output_hold();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_epochs.size() != 0) begin
            note_failure($sformatf("%0d epoch transactions never arrived",
                                   pending_epochs.size()));
        end
        if (fail_count == 0) begin
            $display("[calendar_date_to_epoch] OK");
        end else begin
            $display("[calendar_date_to_epoch] ERROR");
        end
        $finish;
    end

endmodule
